// ===== hw/rtl/vrst_pkg.sv =====
package vrst_pkg;

    // Number formats.
    localparam int COORD_W      = 16;   // signed Q8.8 coordinate
    localparam int TRIG_W       = 16;   // signed Q1.14 cosine and sine
    localparam int FACTOR_W     = 16;   // signed Q8.8 scale and offset
    localparam int COLOR_W      = 8;
    localparam int ROT_SHIFT    = 14;
    localparam int SCALE_SHIFT  = 8;
    localparam int PROD_W       = COORD_W + TRIG_W;
    localparam int SUM_W        = PROD_W + 2;

    // Rotation slots.
    localparam int MAX_ROTATIONS         = 3;
    localparam int NUM_ROTATIONS_DEFAULT = 3;
    localparam int AXIS_W                = 2;

    localparam logic [AXIS_W-1:0] AXIS_X    = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Y    = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_Z    = 2'd2;
    localparam logic [AXIS_W-1:0] AXIS_SKIP = 2'd3;

    // Configuration port.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 48;
    localparam int AXES_W      = AXIS_W * MAX_ROTATIONS;
    localparam int ROT_CFG_W   = 2 * TRIG_W;
    localparam int XYZ_CFG_W   = 3 * FACTOR_W;

    localparam logic [CFG_INDEX_W-1:0] REG_AXES       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ROT_ONE    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ROT_TWO    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ROT_THREE  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SCALE      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_OFFSET     = 3'd5;

    localparam logic [AXES_W-1:0]    AXES_RESET   = 6'h3F;
    localparam logic [ROT_CFG_W-1:0] ROT_RESET    = 32'h4000_0000;
    localparam logic [XYZ_CFG_W-1:0] SCALE_RESET  = 48'h0100_0100_0100;
    localparam logic [XYZ_CFG_W-1:0] OFFSET_RESET = 48'h0;

    // Rounding biases and clamp limits at the working sum width.
    localparam logic signed [SUM_W-1:0] ROT_BIAS   = SUM_W'(1) <<< (ROT_SHIFT - 1);
    localparam logic signed [SUM_W-1:0] SCALE_BIAS = SUM_W'(1) <<< (SCALE_SHIFT - 1);
    localparam logic signed [SUM_W-1:0] SUM_MAX =
        {{(SUM_W - COORD_W + 1){1'b0}}, {(COORD_W - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN =
        {{(SUM_W - COORD_W + 1){1'b1}}, {(COORD_W - 1){1'b0}}};
    localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W - 1){1'b1}}};
    localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W - 1){1'b0}}};

    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic [COLOR_W-1:0]        color_red;
        logic [COLOR_W-1:0]        color_green;
        logic [COLOR_W-1:0]        color_blue;
    } vrst_in_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic signed [COORD_W-1:0] out_z;
        logic [COLOR_W-1:0]        out_red;
        logic [COLOR_W-1:0]        out_green;
        logic [COLOR_W-1:0]        out_blue;
        logic                      saturated;
    } vrst_out_t;

    // Vertex as it moves down the pipeline; pos[0] is x, pos[1] y, pos[2] z.
    typedef struct packed {
        logic [2:0][COORD_W-1:0] pos;
        logic [COLOR_W-1:0]      red;
        logic [COLOR_W-1:0]      green;
        logic [COLOR_W-1:0]      blue;
        logic                    sat;
    } vrst_work_t;

    // Returns {clipped, value}.
    function automatic logic [COORD_W:0] clamp_coord(input logic signed [SUM_W-1:0] v);
        logic [COORD_W:0] res;
        if (v > SUM_MAX)
            res = {1'b1, COORD_MAX};
        else if (v < SUM_MIN)
            res = {1'b1, COORD_MIN};
        else
            res = {1'b0, v[COORD_W-1:0]};
        return res;
    endfunction

endpackage

// ===== hw/rtl/vrst_rotate.sv =====
module vrst_rotate
    import vrst_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic [AXIS_W-1:0]     axis,
    input  logic [ROT_CFG_W-1:0]  cos_sin,
    input  logic                  vld_in,
    input  vrst_work_t            work_in,
    output logic                  vld_out,
    output vrst_work_t            work_out
);

    // Stage A: pick the plane and form the four products.
    logic                       a_vld_reg;
    vrst_work_t                 a_work_reg;
    logic                       a_skip_reg;
    logic [1:0]                 a_ip_reg;
    logic [1:0]                 a_iq_reg;
    logic signed [PROD_W-1:0]   a_pc_reg;
    logic signed [PROD_W-1:0]   a_qs_reg;
    logic signed [PROD_W-1:0]   a_ps_reg;
    logic signed [PROD_W-1:0]   a_qc_reg;

    logic                       skip_next;
    logic [1:0]                 ip_next;
    logic [1:0]                 iq_next;
    logic signed [COORD_W-1:0]  p_val;
    logic signed [COORD_W-1:0]  q_val;
    logic signed [TRIG_W-1:0]   cs_val;
    logic signed [TRIG_W-1:0]   sn_val;

    always_comb
    begin
        skip_next = 1'b0;
        ip_next   = 2'd1;
        iq_next   = 2'd2;
        case (axis)
            AXIS_X:
            begin
                ip_next = 2'd1;
                iq_next = 2'd2;
            end
            AXIS_Y:
            begin
                ip_next = 2'd2;
                iq_next = 2'd0;
            end
            AXIS_Z:
            begin
                ip_next = 2'd0;
                iq_next = 2'd1;
            end
            default:
            begin
                skip_next = 1'b1;
            end
        endcase
    end

    assign p_val  = $signed(work_in.pos[ip_next]);
    assign q_val  = $signed(work_in.pos[iq_next]);
    assign cs_val = $signed(cos_sin[ROT_CFG_W-1:TRIG_W]);
    assign sn_val = $signed(cos_sin[TRIG_W-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_vld_reg <= 1'b0;
        else if (en)
            a_vld_reg <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_work_reg <= work_in;
            a_skip_reg <= skip_next;
            a_ip_reg   <= ip_next;
            a_iq_reg   <= iq_next;
            a_pc_reg   <= p_val * cs_val;
            a_qs_reg   <= q_val * sn_val;
            a_ps_reg   <= p_val * sn_val;
            a_qc_reg   <= q_val * cs_val;
        end
    end

    // Stage B: add, round half up, clamp and write the pair back.
    logic                       b_vld_reg;
    vrst_work_t                 b_work_reg;
    vrst_work_t                 b_work_next;
    logic signed [SUM_W-1:0]    np_sum;
    logic signed [SUM_W-1:0]    nq_sum;
    logic [COORD_W:0]           np_clamp;
    logic [COORD_W:0]           nq_clamp;

    always_comb
    begin
        np_sum = (SUM_W'(a_pc_reg) - SUM_W'(a_qs_reg) + ROT_BIAS) >>> ROT_SHIFT;
        nq_sum = (SUM_W'(a_ps_reg) + SUM_W'(a_qc_reg) + ROT_BIAS) >>> ROT_SHIFT;
        np_clamp = clamp_coord(np_sum);
        nq_clamp = clamp_coord(nq_sum);
        b_work_next = a_work_reg;
        if (!a_skip_reg)
        begin
            b_work_next.pos[a_ip_reg] = np_clamp[COORD_W-1:0];
            b_work_next.pos[a_iq_reg] = nq_clamp[COORD_W-1:0];
            b_work_next.sat = a_work_reg.sat | np_clamp[COORD_W] | nq_clamp[COORD_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_vld_reg <= 1'b0;
        else if (en)
            b_vld_reg <= a_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            b_work_reg <= b_work_next;
    end

    assign vld_out  = b_vld_reg;
    assign work_out = b_work_reg;

    // A vertex that enters while the pipeline moves passes through stage A and stage B and leaves valid.
    a_valid_flow: assert property (@(posedge clk) disable iff (!rst_n)
        en && vld_in ##1 en |=> vld_out)
        else $error("rotation stage lost a vertex");

    // A skipped slot leaves the position untouched.
    a_skip_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        en && vld_in && axis == AXIS_SKIP ##1 en |=> work_out.pos == $past(work_in.pos, 2))
        else $error("skipped rotation changed the position");

    // Colour rides along unchanged.
    a_color_kept: assert property (@(posedge clk) disable iff (!rst_n)
        en && vld_in ##1 en |=>
        work_out.red == $past(work_in.red, 2) && work_out.green == $past(work_in.green, 2)
        && work_out.blue == $past(work_in.blue, 2))
        else $error("rotation stage altered the colour");

endmodule

// ===== hw/rtl/vrst_scale.sv =====
module vrst_scale
    import vrst_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic [XYZ_CFG_W-1:0]  scale,
    input  logic [XYZ_CFG_W-1:0]  offset,
    input  logic                  vld_in,
    input  vrst_work_t            work_in,
    output logic                  vld_out,
    output vrst_out_t             data_out
);

    // Stage A: one product per axis.
    logic                          a_vld_reg;
    vrst_work_t                    a_work_reg;
    logic [2:0][PROD_W-1:0]        a_prod_reg;
    logic [2:0][PROD_W-1:0]        prod_next;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
            prod_next[k] = $signed(work_in.pos[k]) * $signed(scale[FACTOR_W*k +: FACTOR_W]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_vld_reg <= 1'b0;
        else if (en)
            a_vld_reg <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_work_reg <= work_in;
            a_prod_reg <= prod_next;
        end
    end

    // Stage B: round, add the offset and clamp.
    logic                          b_vld_reg;
    vrst_out_t                     b_out_reg;
    vrst_out_t                     b_out_next;
    logic [2:0][COORD_W:0]         clamp_val;
    logic signed [SUM_W-1:0]       sum_val;
    logic signed [SUM_W-1:0]       off_val;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            off_val = SUM_W'($signed(offset[FACTOR_W*k +: FACTOR_W]));
            sum_val = ((SUM_W'($signed(a_prod_reg[k])) + SCALE_BIAS) >>> SCALE_SHIFT) + off_val;
            clamp_val[k] = clamp_coord(sum_val);
        end
        b_out_next.out_x     = clamp_val[0][COORD_W-1:0];
        b_out_next.out_y     = clamp_val[1][COORD_W-1:0];
        b_out_next.out_z     = clamp_val[2][COORD_W-1:0];
        b_out_next.out_red   = a_work_reg.red;
        b_out_next.out_green = a_work_reg.green;
        b_out_next.out_blue  = a_work_reg.blue;
        b_out_next.saturated = a_work_reg.sat | clamp_val[0][COORD_W]
                               | clamp_val[1][COORD_W] | clamp_val[2][COORD_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_vld_reg <= 1'b0;
        else if (en)
            b_vld_reg <= a_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            b_out_reg <= b_out_next;
    end

    assign vld_out  = b_vld_reg;
    assign data_out = b_out_reg;

    // A clip in an earlier rotation is never dropped.
    a_sat_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        en && vld_in && work_in.sat ##1 en |=> data_out.saturated)
        else $error("saturation flag from a rotation was lost");

endmodule

// ===== hw/rtl/vertex_rotate_scale_translate.sv =====
// Vertex rotate, scale and translate. Each vertex (signed Q8.8 x, y, z and
// an 8-bit RGB colour) goes through up to NUM_ROTATIONS plane rotations in
// slot order, then a per-axis scale and offset; coordinates are clamped to
// 16 bits after every rotation and after the offset, and any clamp raises
// the saturated flag. The colour passes through unchanged. The block takes
// one vertex per clock cycle while the pipeline is not held: every rotation
// is one multiply stage and one add, round and clamp stage, and the scale
// step has the same two stages, the second of which is the output register.
// When the output is not taken the whole pipeline holds, so in_ready equals
// "output register empty or being taken". Configuration writes (cfg_write,
// cfg_index, cfg_data) take effect at once and must only be issued while no
// vertex is in flight. Cosines and sines are signed Q1.14, with the cosine
// in the upper half of each rotation register.
module vertex_rotate_scale_translate
    import vrst_pkg::*;
#(
    parameter int NUM_ROTATIONS = NUM_ROTATIONS_DEFAULT
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  vrst_in_t                in_data,
    output logic                    out_valid,
    input  logic                    out_ready,
    output vrst_out_t               out_data
);

    // Configuration registers. An index past the last register is ignored.
    logic [AXES_W-1:0]     axes_reg;
    logic [ROT_CFG_W-1:0]  rot_reg [MAX_ROTATIONS];
    logic [XYZ_CFG_W-1:0]  scale_reg;
    logic [XYZ_CFG_W-1:0]  offset_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axes_reg   <= AXES_RESET;
            rot_reg[0] <= ROT_RESET;
            rot_reg[1] <= ROT_RESET;
            rot_reg[2] <= ROT_RESET;
            scale_reg  <= SCALE_RESET;
            offset_reg <= OFFSET_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_AXES:      axes_reg   <= cfg_data[AXES_W-1:0];
                REG_ROT_ONE:   rot_reg[0] <= cfg_data[ROT_CFG_W-1:0];
                REG_ROT_TWO:   rot_reg[1] <= cfg_data[ROT_CFG_W-1:0];
                REG_ROT_THREE: rot_reg[2] <= cfg_data[ROT_CFG_W-1:0];
                REG_SCALE:     scale_reg  <= cfg_data[XYZ_CFG_W-1:0];
                REG_OFFSET:    offset_reg <= cfg_data[XYZ_CFG_W-1:0];
                default:       ;
            endcase
        end
    end

    // The pipeline advances as a whole whenever the output register is free
    // or its contents are transferred out in this cycle.
    logic pipe_en;

    assign pipe_en  = !out_valid || out_ready;
    assign in_ready = pipe_en;

    // Link zero is the incoming vertex; link i is the output of rotation i.
    vrst_work_t               work_chain [NUM_ROTATIONS+1];
    logic [NUM_ROTATIONS:0]   vld_chain;

    always_comb
    begin
        work_chain[0].pos[0] = in_data.pos_x;
        work_chain[0].pos[1] = in_data.pos_y;
        work_chain[0].pos[2] = in_data.pos_z;
        work_chain[0].red    = in_data.color_red;
        work_chain[0].green  = in_data.color_green;
        work_chain[0].blue   = in_data.color_blue;
        work_chain[0].sat    = 1'b0;
    end

    assign vld_chain[0] = in_valid;

    for (genvar i = 0; i < NUM_ROTATIONS; i++)
    begin : g_rot
        vrst_rotate u_rotate (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (pipe_en),
            .axis     (axes_reg[AXIS_W*i +: AXIS_W]),
            .cos_sin  (rot_reg[i]),
            .vld_in   (vld_chain[i]),
            .work_in  (work_chain[i]),
            .vld_out  (vld_chain[i+1]),
            .work_out (work_chain[i+1])
        );
    end

    // Scale and translate; its second stage is the output register.
    vrst_scale u_scale (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (pipe_en),
        .scale    (scale_reg),
        .offset   (offset_reg),
        .vld_in   (vld_chain[NUM_ROTATIONS]),
        .work_in  (work_chain[NUM_ROTATIONS]),
        .vld_out  (out_valid),
        .data_out (out_data)
    );

    // A stalled pipeline neither drops nor creates a vertex at any rotation output, and the output stays valid.
    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        !pipe_en |=> $stable(vld_chain[NUM_ROTATIONS:1]) && out_valid)
        else $error("pipeline moved while the output was stalled");

endmodule
